// ----- rtl/prq_pkg.sv -----
// Shared types and codes for the priority ready queue.
package prq_pkg;

	// Command carried in the input tuser bit.
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	// Status codes returned in the output tuser bits.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	// Field widths fixed by the stream format.
	localparam int ID_W      = 4;
	localparam int PRIO_IN_W = 8;
	localparam int OCC_W     = 5;
	localparam int S_DATA_W  = 16;
	localparam int M_DATA_W  = 24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_DEQ_TAKE
	} prq_state_t;

endpackage

// ----- rtl/prq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module prq_ram #(
	parameter int DATA_W = 12,
	parameter int DEPTH  = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [DATA_W-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [DATA_W-1:0]                        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/priority_ready_queue.sv -----
// Priority ready queue: sorted circular buffer with insertion from the tail.
//
// Channel  Dir  Handshake              Content
// -------  ---  ---------------------  ----------------------------------------------
// s_axis   in   s_axis_tvalid/tready   tuser: cmd; tdata: proc_id, proc_priority
// m_axis   out  m_axis_tvalid/tready   tuser: status; tdata: head_id, head_priority,
//                                      occupancy
//
// Full enqueue, empty dequeue and enqueue into an empty queue finish in ST_IDLE; a dequeue
// adds ST_DEQ_TAKE. Other enqueues walk back from the tail, through ST_INS_RD (read) and
// ST_INS_CMP (compare/move) per entry passed, and through ST_INS_PUT if passing all.
// Reset: arst_n clears head pointer, count, the FSM and result valid; RAM contents are left as is.
// Stalls: one item in flight; s_axis_tready is high only when idle and the result
// register is empty or being drained in the same cycle.
module priority_ready_queue #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int PRIORITY_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [3:0] proc_id, [11:4] proc_priority, [15:12] zero
	input  logic [prq_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  logic        s_axis_tuser,  // [0] cmd
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] head_id, [11:4] head_priority, [16:12] occupancy, [23:17] zero
	output logic [prq_pkg::M_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	localparam int AW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW     = $clog2(QUEUE_DEPTH + 1);
	localparam int PW     = PRIORITY_BITS;
	localparam int EW     = prq_pkg::ID_W + PW;
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
	localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(QUEUE_DEPTH);

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
		next_slot = (a == LAST_SLOT) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [AW-1:0] prev_slot(input logic [AW-1:0] a);
		prev_slot = (a == '0) ? LAST_SLOT : a - 1'b1;
	endfunction

	// control state
	prq_pkg::prq_state_t state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] pos_q, pos_d;    // slot being filled during insertion
	logic [CW-1:0] left_q, left_d;  // entries still ahead of pos
	logic [prq_pkg::ID_W-1:0] id_q, id_d;
	logic [PW-1:0] prio_q, prio_d;

	// result register
	logic                         out_valid_q;
	logic [1:0]                   out_status_q;
	logic [prq_pkg::ID_W-1:0]     out_id_q;
	logic [prq_pkg::PRIO_IN_W-1:0] out_prio_q;
	logic [prq_pkg::OCC_W-1:0]    out_occ_q;

	logic                          load_res;
	logic [1:0]                    res_status;
	logic [prq_pkg::ID_W-1:0]      res_id;
	logic [prq_pkg::PRIO_IN_W-1:0] res_prio;
	logic [CW-1:0]                 res_occ;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [EW-1:0] ram_rdata;

	logic                     in_xfer;
	logic [prq_pkg::ID_W-1:0] in_id;
	logic [PW-1:0]            in_prio;
	logic [AW:0]              tail_sum;
	logic [AW-1:0]            tail_slot;
	logic [PW-1:0]            rd_prio;
	logic [prq_pkg::ID_W-1:0] rd_id;

	assign s_axis_tready = (state_q == prq_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign in_id         = s_axis_tdata[3:0];
	assign in_prio       = PW'(s_axis_tdata[11:4]);

	// tail = head + count, wrapped once
	assign tail_sum  = (AW + 1)'(head_q) + (AW + 1)'(count_q);
	assign tail_slot = (tail_sum >= DEPTH_EXT) ? AW'(tail_sum - DEPTH_EXT) : AW'(tail_sum);

	assign rd_prio = ram_rdata[PW-1:0];
	assign rd_id   = ram_rdata[EW-1:PW];

	prq_ram #(
		.DATA_W (EW),
		.DEPTH  (QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prq_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result payload
	always_ff @(posedge clk) begin
		pos_q  <= pos_d;
		left_q <= left_d;
		id_q   <= id_d;
		prio_q <= prio_d;
		if (load_res) begin
			out_status_q <= res_status;
			out_id_q     <= res_id;
			out_prio_q   <= res_prio;
			out_occ_q    <= prq_pkg::OCC_W'(res_occ);
		end
	end

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		count_d    = count_q;
		pos_d      = pos_q;
		left_d     = left_q;
		id_d       = id_q;
		prio_d     = prio_q;
		load_res   = 1'b0;
		res_status = prq_pkg::STATUS_OK;
		res_id     = '0;
		res_prio   = '0;
		res_occ    = count_q;
		ram_we     = 1'b0;
		ram_waddr  = pos_q;
		ram_wdata  = {id_q, prio_q};
		ram_raddr  = head_q;

		unique case (state_q)
			prq_pkg::ST_IDLE: begin
				if (in_xfer) begin
					id_d   = in_id;
					prio_d = in_prio;
					if (s_axis_tuser == prq_pkg::CMD_DEQUEUE) begin
						if (count_q == '0) begin
							load_res   = 1'b1;
							res_status = prq_pkg::STATUS_EMPTY;
						end else begin
							// head slot is being read this cycle
							state_d = prq_pkg::ST_DEQ_TAKE;
						end
					end else if (count_q == FULL_CNT) begin
						load_res   = 1'b1;
						res_status = prq_pkg::STATUS_FULL;
					end else if (count_q == '0) begin
						ram_we    = 1'b1;
						ram_waddr = tail_slot;
						ram_wdata = {in_id, in_prio};
						count_d   = count_q + 1'b1;
						load_res  = 1'b1;
						res_occ   = count_q + 1'b1;
					end else begin
						pos_d   = tail_slot;
						left_d  = count_q;
						state_d = prq_pkg::ST_INS_RD;
					end
				end
			end
			prq_pkg::ST_INS_RD: begin
				ram_raddr = prev_slot(pos_q);
				state_d   = prq_pkg::ST_INS_CMP;
			end
			prq_pkg::ST_INS_CMP: begin
				ram_we = 1'b1;
				if (rd_prio >= prio_q) begin
					// new entry goes behind this one
					count_d  = count_q + 1'b1;
					load_res = 1'b1;
					res_occ  = count_q + 1'b1;
					state_d  = prq_pkg::ST_IDLE;
				end else begin
					// move the lower-priority entry back one slot
					ram_wdata = ram_rdata;
					pos_d     = prev_slot(pos_q);
					left_d    = left_q - 1'b1;
					state_d   = (left_q == CW'(1)) ? prq_pkg::ST_INS_PUT : prq_pkg::ST_INS_RD;
				end
			end
			prq_pkg::ST_INS_PUT: begin
				ram_we   = 1'b1;
				count_d  = count_q + 1'b1;
				load_res = 1'b1;
				res_occ  = count_q + 1'b1;
				state_d  = prq_pkg::ST_IDLE;
			end
			prq_pkg::ST_DEQ_TAKE: begin
				head_d   = next_slot(head_q);
				count_d  = count_q - 1'b1;
				load_res = 1'b1;
				res_id   = rd_id;
				res_prio = prq_pkg::PRIO_IN_W'(rd_prio);
				res_occ  = count_q - 1'b1;
				state_d  = prq_pkg::ST_IDLE;
			end
			default: begin
				state_d = prq_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {7'd0, out_occ_q, out_prio_q, out_id_q};

endmodule

// ----- tb/priority_ready_queue_checker.sv -----
// Scoreboard for the priority ready queue: mirrors the queue and checks every result.
`timescale 1ns / 1ps

module priority_ready_queue_checker #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [3:0] proc_id, [11:4] proc_priority, [15:12] zero
	input  logic        s_axis_tuser,  // [0] cmd
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [23:0] m_axis_tdata,  // [3:0] head_id, [11:4] head_priority, [16:12] occupancy
	input  logic [1:0]  m_axis_tuser,  // [1:0] status
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]                    status;
		logic [prq_pkg::ID_W-1:0]      head_id;
		logic [prq_pkg::PRIO_IN_W-1:0] head_prio;
		logic [prq_pkg::OCC_W-1:0]     occupancy;
	} queue_result_t;

	// mirror of the ready queue, slot 0 is the head
	logic [prq_pkg::ID_W-1:0]      ready_ids   [QUEUE_DEPTH];
	logic [prq_pkg::PRIO_IN_W-1:0] ready_prios [QUEUE_DEPTH];
	int                            ready_count;

	queue_result_t expected_results[$];

	function automatic queue_result_t apply_queue_cmd(logic cmd,
	                                                  logic [prq_pkg::ID_W-1:0] pid,
	                                                  logic [prq_pkg::PRIO_IN_W-1:0] prio);
		queue_result_t r;
		int pos;
		r = '0;
		if (cmd == prq_pkg::CMD_ENQUEUE) begin
			if (ready_count >= QUEUE_DEPTH) begin
				r.status = prq_pkg::STATUS_FULL;
			end else begin
				// new entry goes behind everything of equal or higher priority
				pos = 0;
				while (pos < ready_count && ready_prios[pos] >= prio)
					pos++;
				for (int k = ready_count; k > pos; k--) begin
					ready_ids[k]   = ready_ids[k-1];
					ready_prios[k] = ready_prios[k-1];
				end
				ready_ids[pos]   = pid;
				ready_prios[pos] = prio;
				ready_count++;
				r.status = prq_pkg::STATUS_OK;
			end
		end else begin
			if (ready_count == 0) begin
				r.status = prq_pkg::STATUS_EMPTY;
			end else begin
				r.status    = prq_pkg::STATUS_OK;
				r.head_id   = ready_ids[0];
				r.head_prio = ready_prios[0];
				for (int k = 1; k < ready_count; k++) begin
					ready_ids[k-1]   = ready_ids[k];
					ready_prios[k-1] = ready_prios[k];
				end
				ready_count--;
			end
		end
		r.occupancy = prq_pkg::OCC_W'(ready_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		queue_result_t exp_r;
		queue_result_t got_r;
		if (!arst_n) begin
			ready_count = 0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// result side first; it can never belong to an item taken on this edge
			if (m_axis_tvalid && m_axis_tready) begin
				got_r.status    = m_axis_tuser;
				got_r.head_id   = m_axis_tdata[3:0];
				got_r.head_prio = m_axis_tdata[11:4];
				got_r.occupancy = m_axis_tdata[16:12];
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected: %h", got_r);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got_r.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, got_r.status);
						fail_count++;
					end
					if (got_r.head_id !== exp_r.head_id) begin
						$error("head_id: expected %0d, got %0d", exp_r.head_id, got_r.head_id);
						fail_count++;
					end
					if (got_r.head_prio !== exp_r.head_prio) begin
						$error("head_priority: expected %0d, got %0d",
						       exp_r.head_prio, got_r.head_prio);
						fail_count++;
					end
					if (got_r.occupancy !== exp_r.occupancy) begin
						$error("occupancy: expected %0d, got %0d",
						       exp_r.occupancy, got_r.occupancy);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(apply_queue_cmd(s_axis_tuser, s_axis_tdata[3:0],
				                                           s_axis_tdata[11:4]));
			pending = expected_results.size();
		end
	end

endmodule

// ----- tb/priority_ready_queue_tb.sv -----
// Top-level testbench for the priority ready queue: stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module priority_ready_queue_tb;

	localparam int QUEUE_DEPTH  = 16;
	localparam int RANDOM_ITEMS = 1500;
	// final stretch of the random part runs with no gaps on either side
	localparam int QUIET_ITEMS  = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // [3:0] proc_id, [11:4] proc_priority, [15:12] zero
	logic        s_axis_tuser = prq_pkg::CMD_ENQUEUE;  // [0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // [3:0] head_id, [11:4] head_priority, [16:12] occupancy
	logic [1:0]  m_axis_tuser;  // [1:0] status

	int fail_count;
	int pending;

	// gap control, switched per phase by the stimulus process
	bit send_gaps  = 1'b0;
	bit drain_gaps = 1'b0;
	int stall_left = 0;

	always #5 clk = ~clk;

	priority_ready_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.PRIORITY_BITS(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	priority_ready_queue_checker #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Result-side backpressure: while drain_gaps is set, ready drops for bursts of random length.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (drain_gaps && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Present one request and hold it until the transfer happens.
	// Called right after a rising edge; valid is only lowered when a gap is inserted.
	task automatic send_request(logic cmd, logic [prq_pkg::ID_W-1:0] pid,
	                            logic [prq_pkg::PRIO_IN_W-1:0] prio);
		int gap;
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			s_axis_tvalid <= 1'b0;
			// junk on the data lines while idle must not matter
			s_axis_tdata <= {4'b0, 12'($urandom)};
			s_axis_tuser <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {4'b0, prio, pid};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	function automatic logic [prq_pkg::PRIO_IN_W-1:0] pick_priority();
		// half the time a coarse set of levels, so ties are common
		if ($urandom_range(0, 1) == 0)
			return prq_pkg::PRIO_IN_W'($urandom_range(0, 3) * 85);
		return prq_pkg::PRIO_IN_W'($urandom_range(0, 255));
	endfunction

	initial begin
		int sent;
		int phase_len;
		int enq_pct;
		logic cmd;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// dequeue on empty, with the ignored fields at their maxima
		send_request(prq_pkg::CMD_DEQUEUE, 4'd15, 8'd255);
		send_request(prq_pkg::CMD_ENQUEUE, 4'd0, 8'd0);
		send_request(prq_pkg::CMD_ENQUEUE, 4'd15, 8'd255);
		// three equal priorities: must leave in arrival order
		send_request(prq_pkg::CMD_ENQUEUE, 4'd5, 8'd128);
		send_request(prq_pkg::CMD_ENQUEUE, 4'd6, 8'd128);
		send_request(prq_pkg::CMD_ENQUEUE, 4'd7, 8'd128);
		// duplicate id, ties with the lowest entry
		send_request(prq_pkg::CMD_ENQUEUE, 4'd5, 8'd0);
		// ties with the current head, goes second
		send_request(prq_pkg::CMD_ENQUEUE, 4'd9, 8'd255);
		send_request(prq_pkg::CMD_ENQUEUE, 4'd10, 8'h55);
		send_request(prq_pkg::CMD_ENQUEUE, 4'd11, 8'hAA);
		repeat (9) send_request(prq_pkg::CMD_DEQUEUE, 4'd0, 8'd0);
		// one past empty again
		send_request(prq_pkg::CMD_DEQUEUE, 4'd10, 8'h55);

		// --- random part ---
		// phases bias toward filling or draining so that the full and empty
		// boundaries are hit many times; gaps are toggled per phase
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: enq_pct = 85;
				1: enq_pct = 15;
				default: enq_pct = 50;
			endcase
			if (sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
				send_gaps  = 1'b0;
				drain_gaps = 1'b0;
			end else begin
				send_gaps  = $urandom_range(0, 3) != 0;
				drain_gaps = $urandom_range(0, 3) != 0;
			end
			for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				cmd = ($urandom_range(1, 100) <= enq_pct) ? prq_pkg::CMD_ENQUEUE
				                                          : prq_pkg::CMD_DEQUEUE;
				send_request(cmd, prq_pkg::ID_W'($urandom_range(0, 15)), pick_priority());
				sent++;
			end
		end
		s_axis_tvalid <= 1'b0;

		// drain, then allow for a full-length enqueue walk before the verdict
		while (pending != 0) @(posedge clk);
		repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("priority_ready_queue: match");
		end else begin
			$display("priority_ready_queue: mismatch");
		end
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#5ms;
		$display("priority_ready_queue: mismatch");
		$finish;
	end

endmodule
